@@ src/frame_max_normalize_gamma_to_8bit_core_assert.svh @@
// ----------------------------------------------------------------------------
// fmng assertion macros
// shared concurrent check forms for the frame normalize / gamma core
// ----------------------------------------------------------------------------
`ifndef FRAME_MAX_NORMALIZE_GAMMA_TO_8BIT_CORE_ASSERT_SVH
`define FRAME_MAX_NORMALIZE_GAMMA_TO_8BIT_CORE_ASSERT_SVH

// same-cycle implication
`define FMNG_ASSERT_HOLDS(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fmng check failed");

// next-cycle implication
`define FMNG_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fmng check failed");

`endif

@@ src/fmng_pkg.sv @@
// ----------------------------------------------------------------------------
// fmng_pkg
// shared types, constants and the gamma level function
// ----------------------------------------------------------------------------
package fmng_pkg;

   localparam int PIXEL_W     = 16;
   localparam int LEVEL_W     = 8;
   localparam int SHIFT_W     = 4;
   localparam int ADDR_MAX_W  = 20;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [SHIFT_W-1:0] DIVISOR_SHIFT_RESET = 4'd3;
   localparam logic               CSR_IDX_DIVISOR_SHIFT = 1'b0;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;

   typedef enum logic {
      CMD_WRITE,
      CMD_READ
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type                op;
      logic [ADDR_MAX_W-1:0]     addr;
      logic [PIXEL_W-1:0]        data;
      logic                      last;
   } cmd_type;

   // round(255 * (k / 2^ratio_bits)^0.6), halves up, exact integer search:
   // level >= t when (2t-1)^5 * n^3 <= 32 * 255^5 * k^3
   function automatic logic [LEVEL_W-1:0] gamma_level(input int unsigned k,
                                                      input int unsigned ratio_bits);
      logic [127:0]         rhs;
      logic [127:0]         lhs;
      logic [127:0]         n;
      logic [127:0]         kk;
      logic [127:0]         odd;
      logic [LEVEL_W-1:0]   m;
      logic [LEVEL_W-1:0]   t;
      int                   i;
      int                   b;
      n   = 128'd1 << ratio_bits;
      kk  = 128'(k);
      rhs = 128'd32;
      for (i = 0; i < 5; i++) begin
         rhs = rhs * 128'd255;
      end
      rhs = rhs * kk * kk * kk;
      m = '0;
      for (b = LEVEL_W - 1; b >= 0; b--) begin
         t   = m | (LEVEL_W'(1) << b);
         odd = 128'({t, 1'b0}) - 128'd1;
         lhs = odd * odd * odd * odd * odd * n * n * n;
         if (lhs <= rhs) begin
            m = t;
         end
      end
      return m;
   endfunction

endpackage

@@ src/fmng_queue.sv @@
// ----------------------------------------------------------------------------
// fmng_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
`include "frame_max_normalize_gamma_to_8bit_core_assert.svh"

module fmng_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fmng_pkg::cmd_type wr_cmd,
   input  logic              pop,
   output fmng_pkg::cmd_type rd_cmd,
   output logic              full,
   output logic              empty
);
   import fmng_pkg::*;

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;

   assign full   = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   `FMNG_ASSERT_HOLDS(a_no_push_full, clock, reset, full, !push)
   `FMNG_ASSERT_NEXT(a_push_not_empty, clock, reset, push && !pop, count_ff != '0)

endmodule

@@ src/fmng_front.sv @@
// ----------------------------------------------------------------------------
// fmng_front
// accepts requests, keeps frame bookkeeping and issues buffer commands
// ----------------------------------------------------------------------------
`include "frame_max_normalize_gamma_to_8bit_core_assert.svh"

module fmng_front #(
   parameter int FRAME_PIXELS = 262144
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [fmng_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic                          req_frame_end,
   input  logic [fmng_pkg::SHIFT_W-1:0]  divisor_shift,
   input  logic                          q_full,
   output logic                          q_push,
   output fmng_pkg::cmd_type             q_cmd
);
   import fmng_pkg::*;

   localparam int COUNT_W = $clog2(FRAME_PIXELS + 1);
   localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   logic [PIXEL_W-1:0]  running_max_ff;
   logic [PIXEL_W-1:0]  running_max_in;
   logic [COUNT_W-1:0]  load_count_ff;
   logic [COUNT_W-1:0]  load_count_in;
   logic [COUNT_W-1:0]  drain_index_ff;
   logic [COUNT_W-1:0]  drain_index_in;
   logic                frame_ready_ff;
   logic                frame_ready_in;
   logic [PIXEL_W-1:0]  divisor_ff;
   logic [PIXEL_W-1:0]  divisor_in;

   logic                accept;
   logic [COUNT_W-1:0]  base_count;
   logic [PIXEL_W-1:0]  base_max;
   logic                store;
   logic [PIXEL_W-1:0]  new_max;
   logic [COUNT_W-1:0]  drain_next;
   logic                drain_last;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign base_count = frame_ready_ff ? '0 : load_count_ff;
   assign base_max   = frame_ready_ff ? '0 : running_max_ff;
   assign store      = (base_count != COUNT_W'(FRAME_PIXELS));
   assign new_max    = (store && (req_pixel > base_max)) ? req_pixel : base_max;
   assign drain_next = drain_index_ff + COUNT_W'(1);
   assign drain_last = (drain_next == load_count_ff);

   always_comb begin
      running_max_in = running_max_ff;
      load_count_in  = load_count_ff;
      drain_index_in = drain_index_ff;
      frame_ready_in = frame_ready_ff;
      divisor_in     = divisor_ff;
      q_push         = 1'b0;
      q_cmd.op       = CMD_WRITE;
      q_cmd.addr     = ADDR_MAX_W'(base_count[ADDR_W-1:0]);
      q_cmd.data     = req_pixel;
      q_cmd.last     = 1'b0;
      if (accept) begin
         unique case (req_func)
            FUNC_LOAD: begin
               running_max_in = new_max;
               load_count_in  = base_count + COUNT_W'(store);
               drain_index_in = '0;
               frame_ready_in = req_frame_end;
               if (req_frame_end) begin
                  divisor_in = new_max >> divisor_shift;
               end
               q_push = store;
            end
            FUNC_DRAIN: begin
               if (frame_ready_ff && (drain_index_ff < load_count_ff)) begin
                  q_push         = 1'b1;
                  q_cmd.op       = CMD_READ;
                  q_cmd.addr     = ADDR_MAX_W'(drain_index_ff[ADDR_W-1:0]);
                  q_cmd.data     = divisor_ff;
                  q_cmd.last     = drain_last;
                  drain_index_in = drain_next;
                  if (drain_last) begin
                     running_max_in = '0;
                     load_count_in  = '0;
                     drain_index_in = '0;
                     frame_ready_in = 1'b0;
                  end
               end
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_max_ff <= '0;
         load_count_ff  <= '0;
         drain_index_ff <= '0;
         frame_ready_ff <= 1'b0;
         divisor_ff     <= '0;
      end else begin
         running_max_ff <= running_max_in;
         load_count_ff  <= load_count_in;
         drain_index_ff <= drain_index_in;
         frame_ready_ff <= frame_ready_in;
         divisor_ff     <= divisor_in;
      end
   end

   `FMNG_ASSERT_HOLDS(a_ready_has_pixels, clock, reset, frame_ready_ff, drain_index_ff < load_count_ff)
   `FMNG_ASSERT_HOLDS(a_idle_drain_zero, clock, reset, !frame_ready_ff, drain_index_ff == '0)

endmodule

@@ src/fmng_back.sv @@
// ----------------------------------------------------------------------------
// fmng_back
// frame buffer, bit-serial ratio divider, gamma rom and result register
// ----------------------------------------------------------------------------
`include "frame_max_normalize_gamma_to_8bit_core_assert.svh"

module fmng_back #(
   parameter int FRAME_PIXELS = 262144,
   parameter int RATIO_BITS   = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  fmng_pkg::cmd_type             q_cmd,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fmng_pkg::LEVEL_W-1:0]  rsp_level,
   output logic                          rsp_final_res
);
   import fmng_pkg::*;

   localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int ONE    = 1 << RATIO_BITS;
   localparam int Q_W    = RATIO_BITS + 1;
   localparam int STEP_W = $clog2(Q_W);
   localparam int REM_W  = PIXEL_W + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_PUT    = 3'd4;

   logic [PIXEL_W-1:0]  frame_mem [FRAME_PIXELS];
   logic [LEVEL_W-1:0]  gamma_rom [0:ONE];

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [PIXEL_W-1:0]  pix_ff;
   logic [PIXEL_W-1:0]  div_ff;
   logic [PIXEL_W-1:0]  div_in;
   logic                last_ff;
   logic                last_in;
   logic [REM_W-1:0]    rem_ff;
   logic [REM_W-1:0]    rem_in;
   logic [Q_W-1:0]      q_ff;
   logic [Q_W-1:0]      q_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic [LEVEL_W-1:0]  rsp_level_in;
   logic                rsp_final_ff;
   logic                rsp_final_in;

   logic                mem_we;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_addr;
   logic [REM_W-1:0]    div_ext;
   logic                rem_ge;
   logic [REM_W-1:0]    rem_diff;
   logic [Q_W-1:0]      ratio_idx;

   for (genvar gk = 0; gk <= ONE; gk++) begin : g_rom
      localparam logic [LEVEL_W-1:0] LEVEL = gamma_level(gk, RATIO_BITS);
      assign gamma_rom[gk] = LEVEL;
   end

   assign mem_addr  = q_cmd.addr[ADDR_W-1:0];
   assign div_ext   = {1'b0, div_ff};
   assign rem_ge    = (rem_ff >= div_ext);
   assign rem_diff  = rem_ge ? (rem_ff - div_ext) : rem_ff;
   assign ratio_idx = (q_ff > Q_W'(ONE)) ? Q_W'(ONE) : q_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_final_res = rsp_final_ff;

   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_final_in = rsp_final_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_cmd.op == CMD_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  mem_re   = 1'b1;
                  div_in   = q_cmd.data;
                  last_in  = q_cmd.last;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            if (div_ff == '0) begin
               level_in = (pix_ff == '0) ? LEVEL_ZERO : LEVEL_MAX;
               state_in = ST_PUT;
            end else if ({1'b0, pix_ff} >= {div_ff, 1'b0}) begin
               q_in     = Q_W'(ONE);
               state_in = ST_LOOKUP;
            end else begin
               rem_in   = {1'b0, pix_ff};
               q_in     = '0;
               step_in  = STEP_W'(Q_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            q_in   = {q_ff[Q_W-2:0], rem_ge};
            rem_in = {rem_diff[PIXEL_W-1:0], 1'b0};
            if (step_ff == '0) begin
               state_in = ST_LOOKUP;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_LOOKUP: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_final_in = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      last_ff      <= last_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      step_ff      <= step_in;
      rsp_level_ff <= rsp_level_in;
      rsp_final_ff <= rsp_final_in;
      if (state_ff == ST_LOOKUP) begin
         level_ff <= gamma_rom[ratio_idx];
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= q_cmd.data;
      end
      if (mem_re) begin
         pix_ff <= frame_mem[mem_addr];
      end
   end

   `FMNG_ASSERT_HOLDS(a_rem_bound, clock, reset, state_ff == ST_DIV, rem_ff < {div_ff, 1'b0})

endmodule

@@ src/frame_max_normalize_gamma_to_8bit_core.sv @@
// ----------------------------------------------------------------------------
// frame_max_normalize_gamma_to_8bit_core
// Converts a 16-bit infrared frame to 8 bits. Load requests (func 0) store
// pixels in a FRAME_PIXELS-word frame buffer and track the frame maximum; the
// load with frame_end closes the frame and latches max >> divisor_shift as the
// divisor. Drain requests (func 1) then return one level per stored pixel in
// order: round(255 * r^0.6) with r = pixel / divisor in Q(RATIO_BITS), clamped
// to 1; a zero divisor gives 255, or 0 for a zero pixel. final_res marks the
// frame's last result. A load on a closed frame drops what was not drained.
// Loads only write the buffer. A drain passes in the back end through the
// buffer read, the one-bit-per-cycle ratio divider, the gamma rom read and the
// result register; a zero divisor skips divider and rom, a pixel of twice the
// divisor or more skips the divider, and a stalled result adds its stall. A
// four-entry command queue lets the request side run ahead meanwhile. The
// frame buffer has no clear pass and is usable right after reset.
// divisor_shift sits at byte address 0 of the register port (reset 3); the
// user must see that it is written only while the core is idle, which the
// core itself does not enforce.
// ----------------------------------------------------------------------------
module frame_max_normalize_gamma_to_8bit_core #(
   parameter int FRAME_PIXELS = 262144,
   parameter int RATIO_BITS   = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [fmng_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fmng_pkg::LEVEL_W-1:0]      rsp_level,
   output logic                              rsp_final_res,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fmng_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fmng_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fmng_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import fmng_pkg::*;

   logic [SHIFT_W-1:0]  divisor_shift_ff;
   logic [SHIFT_W-1:0]  divisor_shift_in;
   logic                csr_hit;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   cmd_type             push_cmd;
   cmd_type             head_cmd;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1] == CSR_IDX_DIVISOR_SHIFT);
   assign prdata  = csr_hit ? CSR_DATA_W'(divisor_shift_ff) : '0;

   always_comb begin
      divisor_shift_in = divisor_shift_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         divisor_shift_in = pwdata[SHIFT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_shift_ff <= DIVISOR_SHIFT_RESET;
      end else begin
         divisor_shift_ff <= divisor_shift_in;
      end
   end

   fmng_front #(
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_pixel     (req_pixel),
      .req_frame_end (req_frame_end),
      .divisor_shift (divisor_shift_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   fmng_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (push_cmd),
      .pop    (q_pop),
      .rd_cmd (head_cmd),
      .full   (q_full),
      .empty  (q_empty)
   );

   fmng_back #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .RATIO_BITS   (RATIO_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_cmd         (head_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_final_res (rsp_final_res)
   );

endmodule

@@ verif/tb_frame_max_normalize_gamma_to_8bit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_max_normalize_gamma_to_8bit_core
// Self-checking bench for the frame normalize / gamma core. A shadow of the
// frame buffer, running maximum, latched divisor and gamma table predicts
// every drained level and its last-pixel flag. The run reads the shift
// register after reset, then walks a short table of directed requests. It
// then runs random frames under several shift settings, extremes included.
// Both handshake sides stall and idle at random.
// ----------------------------------------------------------------------------
module tb_frame_max_normalize_gamma_to_8bit_core;
   import fmng_pkg::*;

   localparam int FRAME_PIXELS  = 262144;
   localparam int RATIO_BITS    = 12;
   localparam int RATIO_ONE     = 1 << RATIO_BITS;
   localparam int RATIO_W       = PIXEL_W + RATIO_BITS;
   localparam int DRAIN_CYCLES  = RATIO_BITS + 5;
   localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 1) * DRAIN_CYCLES + 10;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_N    = 23;
   localparam int RANDOM_ITEMS  = 420;
   localparam int PHASES        = 6;

   typedef struct packed {
      logic                func;
      logic [PIXEL_W-1:0]  pixel;
      logic                frame_end;
      logic                fixed;
      logic [LEVEL_W-1:0]  level;
      logic                final_res;
   } request_row_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic                final_res;
   } level_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   logic [PIXEL_W-1:0]    req_pixel;
   logic                  req_frame_end;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [LEVEL_W-1:0]    rsp_level;
   logic                  rsp_final_res;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit   [PIXEL_W-1:0]    frame_shadow [FRAME_PIXELS];
   logic [LEVEL_W-1:0]    gamma_lut [RATIO_ONE + 1];
   logic [PIXEL_W-1:0]    frame_peak;
   logic [PIXEL_W-1:0]    frame_divisor;
   logic [SHIFT_W-1:0]    shift_setting;
   int                    stored_count;
   int                    drain_pos;
   bit                    frame_closed;
   level_type             expected_levels [$];
   int                    errors;
   int                    random_items;
   int                    cycle_count = 0;
   bit                    calm;

   frame_max_normalize_gamma_to_8bit_core #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .RATIO_BITS   (RATIO_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_pixel     (req_pixel),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_final_res (rsp_final_res),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_frame_max_normalize_gamma_to_8bit_core: FAIL");
         $finish;
      end
   end

   // round(255 * r^0.6) by exact integer search, halves rounded up
   initial begin : gamma_build
      logic [127:0] target_val;
      logic [127:0] base;
      logic [127:0] lhs;
      int           k;
      int           m;
      int           i;
      bit           climbing;
      m = 0;
      for (k = 0; k <= RATIO_ONE; k++) begin
         target_val = 128'd32;
         for (i = 0; i < 5; i++) target_val = target_val * 128'd255;
         target_val = target_val * 128'(k) * 128'(k) * 128'(k);
         climbing = 1'b1;
         while (climbing && m < 255) begin
            base = 128'(2 * m + 1);
            lhs  = base * base * base * base * base
                   * 128'(RATIO_ONE) * 128'(RATIO_ONE) * 128'(RATIO_ONE);
            if (lhs > target_val) begin
               climbing = 1'b0;
            end else begin
               m++;
            end
         end
         gamma_lut[k] = LEVEL_W'(m);
      end
   end

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic clear_frame();
      frame_peak   = '0;
      stored_count = 0;
      drain_pos    = 0;
      frame_closed = 1'b0;
   endtask

   task automatic apply_request(input request_row_type r, output bit produced,
                                output level_type result);
      logic [PIXEL_W-1:0]  p;
      logic [RATIO_W-1:0]  ratio;
      produced = 1'b0;
      result   = '0;
      if (r.func == FUNC_LOAD) begin
         if (frame_closed) clear_frame();
         // a full buffer drops the pixel but still honors frame_end
         if (stored_count < FRAME_PIXELS) begin
            frame_shadow[stored_count] = r.pixel;
            stored_count++;
            if (r.pixel > frame_peak) frame_peak = r.pixel;
         end
         if (r.frame_end) begin
            frame_divisor = frame_peak >> shift_setting;
            drain_pos     = 0;
            frame_closed  = 1'b1;
         end
      end else if (frame_closed && drain_pos < stored_count) begin
         p = frame_shadow[drain_pos];
         if (frame_divisor == '0) begin
            result.level = (p == '0) ? LEVEL_ZERO : LEVEL_MAX;
         end else begin
            ratio = {p, {RATIO_BITS{1'b0}}} / frame_divisor;
            if (ratio > RATIO_ONE) ratio = RATIO_W'(RATIO_ONE);
            result.level = gamma_lut[ratio];
         end
         drain_pos++;
         result.final_res = (drain_pos == stored_count);
         produced = 1'b1;
         if (result.final_res) clear_frame();
      end
   endtask

   task automatic send_request(input request_row_type r, output bit counted);
      int        gap;
      bit        produced;
      level_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_func      <= r.func;
      req_pixel     <= r.pixel;
      req_frame_end <= r.frame_end;
      do @(posedge clock); while (req_stall);
      apply_request(r, produced, predicted);
      if (produced) begin
         if (r.fixed) begin
            predicted.level     = r.level;
            predicted.final_res = r.final_res;
         end
         expected_levels.push_back(predicted);
      end
      counted = (r.func == FUNC_LOAD) || produced;
   endtask

   task automatic quiesce(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CSR_ADDR_W'(4 * CSR_IDX_DIVISOR_SHIFT);
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_shift(input logic [SHIFT_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_transfer(1'b1, CSR_DATA_W'(value), readback);
      shift_setting = value;
      csr_transfer(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(value)) begin
         $error("divisor_shift expected %0d actual %0d", value, readback);
         errors++;
      end
   endtask

   always @(posedge clock) begin : level_check
      level_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            $error("rsp_level unexpected result, actual %0d", rsp_level);
            errors++;
         end else begin
            want = expected_levels.pop_front();
            if (rsp_level !== want.level) begin
               $error("rsp_level expected %0d actual %0d", want.level, rsp_level);
               errors++;
            end
            if (rsp_final_res !== want.final_res) begin
               $error("rsp_final_res expected %0d actual %0d", want.final_res,
                      rsp_final_res);
               errors++;
            end
         end
      end
   end

   initial begin : rsp_pacing
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = pick_gap();
         if (run > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (run - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   end

   initial begin : stimulus
      request_row_type       directed_rows [DIRECTED_N];
      logic [SHIFT_W-1:0]    shift_plan [PHASES];
      request_row_type       item;
      logic [CSR_DATA_W-1:0] readback;
      bit                    counted;
      int                    phase;
      int                    target;
      int                    frame_len;
      int                    drain_count;
      int                    remaining;
      int                    bound;
      int                    i;
      int                    j;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_LOAD;
      req_pixel     = '0;
      req_frame_end = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      errors        = 0;
      random_items  = 0;
      calm          = 1'b0;
      shift_setting = DIVISOR_SHIFT_RESET;
      frame_divisor = '0;
      clear_frame();

      directed_rows = '{
         '{FUNC_DRAIN, 16'h0000, 1'b1, 1'b0, LEVEL_ZERO, 1'b0},  // nothing loaded yet
         '{FUNC_LOAD,  16'h0000, 1'b1, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_DRAIN, 16'hffff, 1'b0, 1'b1, LEVEL_ZERO, 1'b1},  // zero divisor, zero pixel
         '{FUNC_LOAD,  16'h0005, 1'b1, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_DRAIN, 16'h0000, 1'b1, 1'b1, LEVEL_MAX,  1'b1},  // zero divisor
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},  // frame already drained
         '{FUNC_LOAD,  16'hffff, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'h0000, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'h1fff, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'h0001, 1'b1, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b1, LEVEL_MAX,  1'b0},  // ratio clamped to one
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b1, LEVEL_ZERO, 1'b0},
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b1, LEVEL_MAX,  1'b0},  // ratio exactly one
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b1, LEVEL_ZERO, 1'b1},  // ratio truncates to zero
         '{FUNC_LOAD,  16'd40000, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'd12345, 1'b1, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'd100,   1'b1, 1'b0, LEVEL_ZERO, 1'b0},  // drops undrained frame
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'h8000, 1'b0, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_LOAD,  16'h7fff, 1'b1, 1'b0, LEVEL_ZERO, 1'b0},
         '{FUNC_DRAIN, 16'h0000, 1'b0, 1'b1, LEVEL_MAX,  1'b0},
         '{FUNC_DRAIN, 16'h0000, 1'b1, 1'b1, LEVEL_MAX,  1'b1}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_transfer(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(DIVISOR_SHIFT_RESET)) begin
         $error("divisor_shift expected %0d actual %0d", DIVISOR_SHIFT_RESET, readback);
         errors++;
      end

      for (i = 0; i < DIRECTED_N; i++) send_request(directed_rows[i], counted);

      shift_plan = '{4'd0, 4'd15, SHIFT_W'($urandom_range(1, 14)),
                     SHIFT_W'($urandom_range(1, 14)), 4'd1, DIVISOR_SHIFT_RESET};
      for (phase = 0; phase < PHASES; phase++) begin
         quiesce(SETTLE_CYCLES);
         program_shift(shift_plan[phase]);
         calm   = (phase == 2);
         target = RANDOM_ITEMS * (phase + 1) / PHASES;
         while (random_items < target) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
            bound     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 65535);
            for (j = 0; j < frame_len; j++) begin
               item      = '0;
               item.func = FUNC_LOAD;
               case ($urandom_range(0, 5))
                  0: item.pixel = '0;
                  1: item.pixel = '1;
                  2: item.pixel = PIXEL_W'(bound);
                  3: item.pixel = PIXEL_W'($urandom_range(0, (bound >> shift_setting) + 2));
                  4: item.pixel = PIXEL_W'($urandom_range(0, bound));
                  default: item.pixel = PIXEL_W'($urandom);
               endcase
               // an early frame_end now and then, so later loads drop the frame
               item.frame_end = (j == frame_len - 1) || ($urandom_range(0, 29) == 0);
               send_request(item, counted);
               random_items += counted;
            end
            remaining = stored_count - drain_pos;
            case ($urandom_range(0, 9))
               7: drain_count = remaining + $urandom_range(1, 3);
               8: drain_count = $urandom_range(0, remaining);
               default: drain_count = remaining;
            endcase
            for (j = 0; j < drain_count; j++) begin
               item           = '0;
               item.func      = FUNC_DRAIN;
               item.pixel     = PIXEL_W'($urandom);
               item.frame_end = 1'($urandom_range(0, 1));
               send_request(item, counted);
               random_items += counted;
            end
            if ($urandom_range(0, 24) == 0) quiesce(0);
         end
      end

      quiesce(SETTLE_CYCLES);
      if (errors == 0) begin
         $display("tb_frame_max_normalize_gamma_to_8bit_core: PASS");
      end else begin
         $display("tb_frame_max_normalize_gamma_to_8bit_core: FAIL");
      end
      $finish;
   end

endmodule
